>>> rtl/dmpi_pkg.sv
// Shared widths, types, codes and clamp function for the dual motor PI speed controller.
package dmpi_pkg;

  // Field widths
  localparam int COUNT_WIDTH = 16;
  localparam int GAIN_WIDTH  = 8;
  localparam int REG8_W      = 8;
  localparam int LIM_W       = 10;
  localparam int ISUM_W      = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = LIM_W;

  // Derived datapath widths: a clamped target needs ISUM_W bits at least
  localparam int TGT_W  = (COUNT_WIDTH > ISUM_W) ? COUNT_WIDTH : ISUM_W;
  localparam int ERR_W  = TGT_W + 1;
  localparam int PROD_W = ERR_W + GAIN_WIDTH;
  localparam int MAG_W  = PROD_W - 1;
  localparam int CMD_W  = PROD_W + 1;

  // Divider step counter width
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic        [GAIN_WIDTH-1:0]  gain_t;
  typedef logic        [LIM_W-1:0]       lim_t;
  typedef logic signed [ISUM_W-1:0]      isum_t;
  typedef logic signed [ERR_W-1:0]       err_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic        [MAG_W-1:0]       mag_t;
  typedef logic signed [CMD_W-1:0]       cmd_t;

  // Drive action codes
  typedef enum logic [1:0] {
    ACT_BRAKE = 2'd0,
    ACT_FWD   = 2'd1,
    ACT_REV   = 2'd2
  } act_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_NUM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_DEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_NUM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_DEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_CLIP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SP_LIM    = 3'd6;

  // Register reset values
  localparam logic [REG8_W-1:0] RST_PROP_NUM  = 8'd2;
  localparam logic [REG8_W-1:0] RST_PROP_DEN  = 8'd1;
  localparam logic [REG8_W-1:0] RST_INTEG_NUM = 8'd0;
  localparam logic [REG8_W-1:0] RST_INTEG_DEN = 8'd100;
  localparam lim_t              RST_INT_CLIP  = 10'd60;
  localparam lim_t              RST_OUT_LIM   = 10'd100;
  localparam lim_t              RST_SP_LIM    = 10'd100;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MULP,
    ST_DIVP,
    ST_WAITP,
    ST_MULI,
    ST_DIVI,
    ST_WAITI,
    ST_CLIP,
    ST_CMD,
    ST_LIM,
    ST_OUT
  } state_t;

  typedef struct packed {
    gain_t prop_num;
    gain_t prop_den;
    gain_t integ_num;
    gain_t integ_den;
    lim_t  int_clip;
    lim_t  out_lim;
    lim_t  sp_lim;
  } cfg_t;

  typedef struct packed {
    logic  start;
    mag_t  dividend;
    gain_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quo;
  } div_rsp_t;

  typedef struct packed {
    act_t l_act;
    lim_t l_duty;
    act_t r_act;
    lim_t r_duty;
  } res_t;

  // Clamp a signed value to plus or minus an unsigned limit
  function automatic cmd_t clamp_sym(input cmd_t v, input lim_t lim);
    cmd_t l;
    cmd_t r;
    l = cmd_t'($signed({1'b0, lim}));
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/dmpi_div.sv
// Restoring serial divider: unsigned magnitude by gain denominator, one quotient bit a cycle.
module dmpi_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dmpi_pkg::div_req_t  req,
  output dmpi_pkg::div_rsp_t  rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [dmpi_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  dmpi_pkg::mag_t                    dvd_r, dvd_nxt;
  dmpi_pkg::gain_t                   rem_r, rem_nxt;
  dmpi_pkg::gain_t                   dsr_r, dsr_nxt;

  logic [dmpi_pkg::GAIN_WIDTH:0] trial;
  logic [dmpi_pkg::GAIN_WIDTH:0] diff;
  logic                          ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_r, dvd_r[dmpi_pkg::MAG_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  // Next values: load on start, otherwise shift one quotient bit in
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = busy_r && (cnt_r == dmpi_pkg::DIV_CNT_W'(1));
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = dmpi_pkg::DIV_CNT_W'(dmpi_pkg::MAG_W);
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - dmpi_pkg::DIV_CNT_W'(1);
      busy_nxt = (cnt_r != dmpi_pkg::DIV_CNT_W'(1));
      dvd_nxt  = {dvd_r[dmpi_pkg::MAG_W-2:0], ge};
      rem_nxt  = ge ? diff[dmpi_pkg::GAIN_WIDTH-1:0] : trial[dmpi_pkg::GAIN_WIDTH-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;

endmodule

>>> rtl/dmpi_seq.sv
// Sequencer and shared datapath: error, multiply, divide, integrate and clamp for each motor.
module dmpi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmpi_pkg::count_t    left_target,
  input  dmpi_pkg::count_t    right_target,
  input  dmpi_pkg::count_t    left_pulses,
  input  dmpi_pkg::count_t    right_pulses,
  input  dmpi_pkg::cfg_t      cfg,
  output dmpi_pkg::div_req_t  div_req,
  input  dmpi_pkg::div_rsp_t  div_rsp,
  input  logic                out_free,
  output logic                res_valid,
  output dmpi_pkg::res_t      res
);

  dmpi_pkg::state_t  state_r, state_nxt;
  logic              m_r, m_nxt;
  dmpi_pkg::count_t  tgt_r [2];
  dmpi_pkg::count_t  tgt_nxt [2];
  dmpi_pkg::count_t  cnt_r [2];
  dmpi_pkg::count_t  cnt_nxt [2];
  dmpi_pkg::isum_t   isum_r [2];
  dmpi_pkg::isum_t   isum_nxt [2];
  dmpi_pkg::err_t    err_r, err_nxt;
  dmpi_pkg::prod_t   prod_r, prod_nxt;
  logic              neg_r, neg_nxt;
  dmpi_pkg::prod_t   prop_r, prop_nxt;
  dmpi_pkg::cmd_t    acc_r, acc_nxt;
  dmpi_pkg::cmd_t    cmd_r, cmd_nxt;
  dmpi_pkg::res_t    res_r, res_nxt;

  dmpi_pkg::cmd_t    tgt_clamp;
  dmpi_pkg::prod_t   mul_a, mul_b;
  dmpi_pkg::prod_t   quo_u, quo_s;
  dmpi_pkg::prod_t   prod_abs;
  dmpi_pkg::gain_t   den_sel;
  dmpi_pkg::cmd_t    cmd_lim, cmd_abs;
  dmpi_pkg::act_t    act_sel;
  dmpi_pkg::lim_t    duty_sel;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmpi_pkg::ST_IDLE:  if (in_valid) state_nxt = dmpi_pkg::ST_ERR;
      dmpi_pkg::ST_ERR:   state_nxt = dmpi_pkg::ST_MULP;
      dmpi_pkg::ST_MULP:  state_nxt = dmpi_pkg::ST_DIVP;
      dmpi_pkg::ST_DIVP:  state_nxt = dmpi_pkg::ST_WAITP;
      dmpi_pkg::ST_WAITP: if (div_rsp.done) state_nxt = dmpi_pkg::ST_MULI;
      dmpi_pkg::ST_MULI:  state_nxt = dmpi_pkg::ST_DIVI;
      dmpi_pkg::ST_DIVI:  state_nxt = dmpi_pkg::ST_WAITI;
      dmpi_pkg::ST_WAITI: if (div_rsp.done) state_nxt = dmpi_pkg::ST_CLIP;
      dmpi_pkg::ST_CLIP:  state_nxt = dmpi_pkg::ST_CMD;
      dmpi_pkg::ST_CMD:   state_nxt = dmpi_pkg::ST_LIM;
      dmpi_pkg::ST_LIM:   state_nxt = m_r ? dmpi_pkg::ST_OUT : dmpi_pkg::ST_ERR;
      dmpi_pkg::ST_OUT:   if (out_free) state_nxt = dmpi_pkg::ST_IDLE;
      default:            state_nxt = dmpi_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = (state_r == dmpi_pkg::ST_IDLE);
    res_valid = (state_r == dmpi_pkg::ST_OUT) && out_free;
  end

  // Shared arithmetic: setpoint clamp, one multiplier, divider request, signed quotient, output clamp
  always_comb begin
    tgt_clamp = dmpi_pkg::clamp_sym(dmpi_pkg::cmd_t'(tgt_r[m_r]), cfg.sp_lim);
    mul_a = dmpi_pkg::prod_t'($signed({1'b0,
              (state_r == dmpi_pkg::ST_MULI) ? cfg.integ_num : cfg.prop_num}));
    mul_b = dmpi_pkg::prod_t'(err_r);
    prod_abs = prod_r[dmpi_pkg::PROD_W-1] ? -prod_r : prod_r;
    den_sel  = (state_r == dmpi_pkg::ST_DIVI) ? cfg.integ_den : cfg.prop_den;
    div_req.start    = (state_r == dmpi_pkg::ST_DIVP) || (state_r == dmpi_pkg::ST_DIVI);
    div_req.dividend = dmpi_pkg::mag_t'(prod_abs);
    // A zero denominator acts as one
    div_req.divisor  = (den_sel == '0) ? dmpi_pkg::gain_t'(1) : den_sel;
    quo_u = dmpi_pkg::prod_t'({1'b0, div_rsp.quo});
    quo_s = neg_r ? -quo_u : quo_u;
    cmd_lim = dmpi_pkg::clamp_sym(cmd_r, cfg.out_lim);
    cmd_abs = (cmd_lim < 0) ? -cmd_lim : cmd_lim;
    duty_sel = dmpi_pkg::lim_t'(cmd_abs);
    if (cmd_lim == '0) begin
      act_sel = dmpi_pkg::ACT_BRAKE;
    end else if (cmd_lim > 0) begin
      act_sel = dmpi_pkg::ACT_FWD;
    end else begin
      act_sel = dmpi_pkg::ACT_REV;
    end
  end

  // Datapath next values, one step per state
  always_comb begin
    m_nxt    = m_r;
    tgt_nxt  = tgt_r;
    cnt_nxt  = cnt_r;
    isum_nxt = isum_r;
    err_nxt  = err_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    prop_nxt = prop_r;
    acc_nxt  = acc_r;
    cmd_nxt  = cmd_r;
    res_nxt  = res_r;
    case (state_r)
      dmpi_pkg::ST_IDLE: begin
        if (in_valid) begin
          m_nxt      = 1'b0;
          tgt_nxt[0] = left_target;
          tgt_nxt[1] = right_target;
          cnt_nxt[0] = left_pulses;
          cnt_nxt[1] = right_pulses;
        end
      end
      dmpi_pkg::ST_ERR: begin
        err_nxt = dmpi_pkg::err_t'(tgt_clamp) - dmpi_pkg::err_t'(cnt_r[m_r]);
      end
      dmpi_pkg::ST_MULP, dmpi_pkg::ST_MULI: begin
        prod_nxt = mul_a * mul_b;
      end
      dmpi_pkg::ST_DIVP, dmpi_pkg::ST_DIVI: begin
        neg_nxt = prod_r[dmpi_pkg::PROD_W-1];
      end
      dmpi_pkg::ST_WAITP: begin
        if (div_rsp.done) prop_nxt = quo_s;
      end
      dmpi_pkg::ST_WAITI: begin
        if (div_rsp.done) begin
          acc_nxt = dmpi_pkg::cmd_t'(isum_r[m_r]) + dmpi_pkg::cmd_t'(quo_s);
        end
      end
      dmpi_pkg::ST_CLIP: begin
        isum_nxt[m_r] = dmpi_pkg::isum_t'(dmpi_pkg::clamp_sym(acc_r, cfg.int_clip));
      end
      dmpi_pkg::ST_CMD: begin
        cmd_nxt = dmpi_pkg::cmd_t'(prop_r) + dmpi_pkg::cmd_t'(isum_r[m_r]);
      end
      dmpi_pkg::ST_LIM: begin
        m_nxt = ~m_r;
        if (m_r) begin
          res_nxt.r_act  = act_sel;
          res_nxt.r_duty = duty_sel;
        end else begin
          res_nxt.l_act  = act_sel;
          res_nxt.l_duty = duty_sel;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and integral sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dmpi_pkg::ST_IDLE;
      m_r       <= 1'b0;
      isum_r[0] <= '0;
      isum_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      isum_r  <= isum_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    cnt_r  <= cnt_nxt;
    err_r  <= err_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    prop_r <= prop_nxt;
    acc_r  <= acc_nxt;
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> rtl/dual_motor_pi_speed_controller.sv
// Top level of the dual motor PI speed controller: registers, sequencer, divider, output stage.
//
//   channel  direction  handshake                  payload
//   in_      input      in_valid / in_ready        left/right target, left/right pulses
//   out_     output     out_valid / out_ready      left/right action, left/right duty
//   cfg_     input      cfg_wr_en                  cfg_index, cfg_wdata
//
// From acceptance to the result entering the output register, a transaction runs four
// divisions (two per motor) through the shared restoring divider, which makes one
// quotient bit a cycle.
// in_ready is high only while the sequencer is idle; a waiting result in the output register
// does not block acceptance of the next transaction. Reset is synchronous and active low and
// clears the registers to their reset values and both integral sums to zero.
module dual_motor_pi_speed_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dmpi_pkg::COUNT_WIDTH-1:0] in_left_target,
  input  logic signed [dmpi_pkg::COUNT_WIDTH-1:0] in_right_target,
  input  logic signed [dmpi_pkg::COUNT_WIDTH-1:0] in_left_pulses,
  input  logic signed [dmpi_pkg::COUNT_WIDTH-1:0] in_right_pulses,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_left_action,
  output logic [dmpi_pkg::LIM_W-1:0]           out_left_duty,
  output logic [1:0]                           out_right_action,
  output logic [dmpi_pkg::LIM_W-1:0]           out_right_duty,
  input  logic                                 cfg_wr_en,
  input  logic [dmpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmpi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  dmpi_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  dmpi_pkg::res_t     out_r, out_nxt;
  dmpi_pkg::div_req_t div_req;
  dmpi_pkg::div_rsp_t div_rsp;
  dmpi_pkg::res_t     seq_res;
  logic               seq_res_valid;
  logic               out_free;

  // Register writes; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        dmpi_pkg::REG_PROP_NUM:
          cfg_nxt.prop_num  = dmpi_pkg::gain_t'(cfg_wdata[dmpi_pkg::REG8_W-1:0]);
        dmpi_pkg::REG_PROP_DEN:
          cfg_nxt.prop_den  = dmpi_pkg::gain_t'(cfg_wdata[dmpi_pkg::REG8_W-1:0]);
        dmpi_pkg::REG_INTEG_NUM:
          cfg_nxt.integ_num = dmpi_pkg::gain_t'(cfg_wdata[dmpi_pkg::REG8_W-1:0]);
        dmpi_pkg::REG_INTEG_DEN:
          cfg_nxt.integ_den = dmpi_pkg::gain_t'(cfg_wdata[dmpi_pkg::REG8_W-1:0]);
        dmpi_pkg::REG_INT_CLIP: cfg_nxt.int_clip = cfg_wdata;
        dmpi_pkg::REG_OUT_LIM:  cfg_nxt.out_lim  = cfg_wdata;
        dmpi_pkg::REG_SP_LIM:   cfg_nxt.sp_lim   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_num  <= dmpi_pkg::gain_t'(dmpi_pkg::RST_PROP_NUM);
      cfg_r.prop_den  <= dmpi_pkg::gain_t'(dmpi_pkg::RST_PROP_DEN);
      cfg_r.integ_num <= dmpi_pkg::gain_t'(dmpi_pkg::RST_INTEG_NUM);
      cfg_r.integ_den <= dmpi_pkg::gain_t'(dmpi_pkg::RST_INTEG_DEN);
      cfg_r.int_clip  <= dmpi_pkg::RST_INT_CLIP;
      cfg_r.out_lim   <= dmpi_pkg::RST_OUT_LIM;
      cfg_r.sp_lim    <= dmpi_pkg::RST_SP_LIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dmpi_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_target  (in_left_target),
    .right_target (in_right_target),
    .left_pulses  (in_left_pulses),
    .right_pulses (in_right_pulses),
    .cfg          (cfg_r),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_free     (out_free),
    .res_valid    (seq_res_valid),
    .res          (seq_res)
  );

  dmpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register: load a finished result, hold it until taken
  always_comb begin
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (seq_res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = seq_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_left_action  = out_r.l_act;
  assign out_left_duty    = out_r.l_duty;
  assign out_right_action = out_r.r_act;
  assign out_right_duty   = out_r.r_duty;

`ifndef SYNTHESIS
  // An accepted transaction occupies the sequencer on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready still high after acceptance");

  // Brake exactly when the left duty is zero
  a_left_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_action == dmpi_pkg::ACT_BRAKE) == (out_left_duty == '0)))
    else $error("left action and duty disagree");

  // Brake exactly when the right duty is zero
  a_right_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_right_action == dmpi_pkg::ACT_BRAKE) == (out_right_duty == '0)))
    else $error("right action and duty disagree");

  // Duty never exceeds the command limit
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_duty <= cfg_r.out_lim) && (out_right_duty <= cfg_r.out_lim)))
    else $error("duty above output limit");
`endif

endmodule
